// File: rtl/core/tts_pkg.sv
package tts_pkg;

	// field widths fixed by the item formats
	localparam int OP_W     = 1;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 11;
	localparam int STATUS_W = 2;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int TAB_STOP = 8;
	localparam int TAB_W    = $clog2(TAB_STOP);

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

	localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
	localparam logic [CHAR_W-1:0] CH_PRINT_MIN = 8'd32;

	typedef enum logic [OP_W-1:0] {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_UNKNOWN = 2'd1,
		STAT_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_TAB,
		ST_SCROLL,
		ST_BLANK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CELL_W-1:0]   cell_data;
		logic [IDX_W-1:0]    cursor_pos;
	} res_t;

endpackage

// File: rtl/core/tts_if.sv
interface tts_in_if;
	logic                       valid;
	logic                       ready;
	logic [tts_pkg::OP_W-1:0]   op;
	logic [tts_pkg::CHAR_W-1:0] char_code;
	logic [tts_pkg::IDX_W-1:0]  cell_index;

	modport source (output valid, output op, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input op, input char_code, input cell_index,
		output ready);
endinterface

interface tts_out_if;
	logic                         valid;
	logic                         ready;
	logic [tts_pkg::STATUS_W-1:0] status;
	logic [tts_pkg::CELL_W-1:0]   cell_data;
	logic [tts_pkg::IDX_W-1:0]    cursor_pos;

	modport source (output valid, output status, output cell_data, output cursor_pos,
		input ready);
	modport sink (input valid, input status, input cell_data, input cursor_pos,
		output ready);
endinterface

// File: rtl/core/tts_mem.sv
module tts_mem #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [tts_pkg::CELL_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [tts_pkg::CELL_W-1:0] rdata
);
	import tts_pkg::*;

	logic [CELL_W-1:0] mem_q [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/tts_ctrl.sv
module tts_ctrl #(
	parameter int COLUMNS = tts_pkg::DEF_COLUMNS,
	parameter int ROWS    = tts_pkg::DEF_ROWS,
	parameter int AW      = $clog2(COLUMNS * ROWS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tts_in_if.sink                     req,
	input  logic                       cfg_we,
	input  logic [tts_pkg::ATTR_W-1:0] cfg_wdata,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [tts_pkg::CELL_W-1:0] mem_wdata,
	output logic                       mem_re,
	output logic [AW-1:0]              mem_raddr,
	input  logic [tts_pkg::CELL_W-1:0] mem_rdata,
	output logic                       res_valid,
	output tts_pkg::res_t              res,
	input  logic                       slot_free
);
	import tts_pkg::*;

	localparam int TOTAL = COLUMNS * ROWS;
	localparam int PW    = AW + 1;
	localparam int CW    = $clog2(COLUMNS);
	localparam int IW    = ((AW > IDX_W) ? AW : IDX_W) + 1;

	localparam logic [PW-1:0] TOTAL_P = PW'(TOTAL);
	localparam logic [PW-1:0] COL_P   = PW'(COLUMNS);
	localparam logic [PW-1:0] LAST_P  = PW'(TOTAL - COLUMNS);
	localparam logic [PW-1:0] END_P   = PW'(TOTAL - 1);
	localparam logic [CW-1:0] COL_MAX = CW'(COLUMNS - 1);
	localparam logic [TAB_W-1:0] TAB_LAST = TAB_W'(TAB_STOP - 1);

	state_t             state_q, state_d;
	logic [AW-1:0]      cursor_q;
	logic [CW-1:0]      col_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [TAB_W-1:0]   tc_q;
	logic [PW-1:0]      ptr_q;
	logic [AW-1:0]      wa_s1;
	logic               wv_s1;
	logic [STATUS_W-1:0] status_q;
	logic [CELL_W-1:0]  data_q;

	logic               accept;
	logic               is_read;
	logic               in_range;
	logic               printable;
	logic [PW-1:0]      cur_ext;
	logic [PW-1:0]      cur_inc;
	logic [PW-1:0]      cur_nl;
	logic [PW-1:0]      cur_cr;
	logic [PW-1:0]      col_ext;
	logic [CW-1:0]      col_inc;
	logic               at_tab_stop;
	logic               scroll_rd;

	assign req.ready   = (state_q == ST_IDLE);
	assign accept      = req.valid && req.ready;
	assign is_read     = (req.op == OP_READ);
	assign in_range    = (IW'(req.cell_index) < IW'(TOTAL));
	assign printable   = (req.char_code >= CH_PRINT_MIN);
	assign cur_ext     = PW'(cursor_q);
	assign col_ext     = PW'(col_q);
	assign cur_inc     = cur_ext + PW'(1);
	assign cur_nl      = cur_ext + COL_P - col_ext;
	assign cur_cr      = cur_ext - col_ext;
	assign col_inc     = (col_q == COL_MAX) ? '0 : col_q + CW'(1);
	assign at_tab_stop = (col_q[TAB_W-1:0] == '0);
	assign scroll_rd   = (ptr_q < TOTAL_P);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (ptr_q == END_P) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (is_read) begin
						state_d = in_range ? ST_READ : ST_DONE;
					end else if (printable) begin
						state_d = (cur_inc >= TOTAL_P) ? ST_SCROLL : ST_DONE;
					end else if (req.char_code == CH_TAB) begin
						state_d = at_tab_stop ? ST_DONE : ST_TAB;
					end else if (req.char_code == CH_LF) begin
						state_d = (cur_nl >= TOTAL_P) ? ST_SCROLL : ST_DONE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_TAB: begin
				if (cur_inc >= TOTAL_P) state_d = ST_SCROLL;
				else if (tc_q == TAB_LAST) state_d = ST_DONE;
			end
			ST_SCROLL: begin
				if (!scroll_rd) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (ptr_q == END_P) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cursor_q;
		mem_wdata = BLANK_CELL;
		mem_re    = 1'b0;
		mem_raddr = AW'(req.cell_index);
		res_valid = (state_q == ST_DONE);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
			end
			ST_IDLE: begin
				if (accept) begin
					if (is_read) begin
						mem_re = in_range;
					end else if (printable) begin
						mem_we    = 1'b1;
						mem_wdata = {attr_q, req.char_code};
					end else if (req.char_code == CH_BS) begin
						mem_we = 1'b1;
						if (col_q != '0) mem_waddr = cursor_q - AW'(1);
					end
				end
			end
			ST_TAB: begin
				mem_we    = (cur_inc < TOTAL_P);
				mem_waddr = cur_inc[AW-1:0];
			end
			ST_SCROLL: begin
				mem_re    = scroll_rd;
				mem_raddr = ptr_q[AW-1:0];
				mem_we    = wv_s1;
				mem_waddr = wa_s1;
				mem_wdata = mem_rdata;
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign res.status     = status_q;
	assign res.cell_data  = data_q;
	assign res.cursor_pos = IDX_W'(cursor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cursor_q <= '0;
			col_q    <= '0;
			attr_q   <= ATTR_RESET;
			tc_q     <= '0;
			ptr_q    <= '0;
			wa_s1    <= '0;
			wv_s1    <= 1'b0;
			status_q <= STAT_DONE;
			data_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) attr_q <= cfg_wdata;
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + PW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						status_q <= STAT_DONE;
						data_q   <= '0;
						tc_q     <= col_q[TAB_W-1:0];
						ptr_q    <= COL_P;
						wv_s1    <= 1'b0;
						if (is_read) begin
							if (!in_range) status_q <= STAT_RANGE;
						end else if (printable) begin
							cursor_q <= cur_inc[AW-1:0];
							col_q    <= col_inc;
						end else begin
							case (req.char_code)
								CH_BS: begin
									if (col_q != '0) begin
										cursor_q <= cursor_q - AW'(1);
										col_q    <= col_q - CW'(1);
									end
								end
								CH_TAB: begin
								end
								CH_LF: begin
									cursor_q <= cur_nl[AW-1:0];
									col_q    <= '0;
								end
								CH_CR: begin
									cursor_q <= cur_cr[AW-1:0];
									col_q    <= '0;
								end
								default: status_q <= STAT_UNKNOWN;
							endcase
						end
					end
				end
				ST_READ: begin
					data_q <= mem_rdata;
				end
				ST_TAB: begin
					if (cur_inc < TOTAL_P) begin
						cursor_q <= cur_inc[AW-1:0];
						col_q    <= col_inc;
						tc_q     <= tc_q + TAB_W'(1);
					end
				end
				ST_SCROLL: begin
					// read one line ahead, write the row above in the next cycle
					wv_s1 <= scroll_rd;
					if (scroll_rd) begin
						wa_s1 <= AW'(ptr_q - COL_P);
						ptr_q <= ptr_q + PW'(1);
					end else begin
						ptr_q <= LAST_P;
					end
				end
				ST_BLANK: begin
					ptr_q <= ptr_q + PW'(1);
					if (ptr_q == END_P) begin
						cursor_q <= LAST_P[AW-1:0];
						col_q    <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/core/text_terminal_screen_writer.sv
// Put item for a printable, backspace, newline, return or unknown byte: the result is
// registered in the done state after acceptance unless it scrolls; a read item adds a read state.
// A tab steps through its cells in the tab state. A scroll walks the cell store once.
// One item is in work at a time; the next is taken while a result waits in the output register.
// After arst_n the store is cleared to blank cells, during which no item is accepted;
// the cursor resets to 0 and the attribute register to 7.
module text_terminal_screen_writer #(
	parameter int COLUMNS = tts_pkg::DEF_COLUMNS,
	parameter int ROWS    = tts_pkg::DEF_ROWS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tts_in_if.sink                     req,
	tts_out_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [tts_pkg::ATTR_W-1:0] cfg_wdata
);
	import tts_pkg::*;

	localparam int TOTAL = COLUMNS * ROWS;
	localparam int AW    = $clog2(TOTAL);

	// cell store port wiring between the sequencer and the memory
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	logic res_valid;
	res_t res;
	logic slot_free;

	// output stage
	logic out_valid_q;
	res_t out_q;

	// One synchronous memory holds the whole screen; read data appears in the cycle after the
	// address, which the sequencer accounts for in its read and scroll states.
	tts_mem #(
		.DEPTH (TOTAL),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer: decodes each item, keeps cursor and column, and runs the clear, tab and
	// scroll walks over the memory.
	tts_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.AW      (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free)
	);

	// The output register takes a new result when it is empty or being drained this cycle.
	assign slot_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	// Hold the payload while the sink stalls; load only when a result is handed over.
	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.cell_data  = out_q.cell_data;
	assign rsp.cursor_pos = out_q.cursor_pos;

endmodule

// File: test/screen_checker.sv
module screen_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	tts_in_if                          req,
	tts_out_if                         rsp,
	input  logic                       cfg_we,
	input  logic [tts_pkg::ATTR_W-1:0] cfg_wdata,
	output int                         outstanding,
	output int                         mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	localparam int COLUMNS      = DEF_COLUMNS;
	localparam int ROWS         = DEF_ROWS;
	localparam int SCREEN_CELLS = COLUMNS * ROWS;

	logic [CELL_W-1:0] screen [SCREEN_CELLS];
	int                cursor_cell;
	logic [ATTR_W-1:0] attr_byte;
	res_t              awaited_replies [$];
	res_t              want;

	initial mismatches = 0;

	// Apply one item to the local copy of the screen and return the reply it should give.
	function automatic res_t emulate_terminal(input op_t op, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		res_t r;
		int   pos;
		int   col;
		logic may_scroll;
		r          = '0;
		pos        = cursor_cell;
		may_scroll = 1'b0;
		if (op == OP_READ) begin
			if (idx < SCREEN_CELLS)
				r.cell_data = screen[idx];
			else
				r.status = STAT_RANGE;
		end else if (ch >= CH_PRINT_MIN) begin
			screen[pos] = {attr_byte, ch};
			pos++;
			may_scroll = 1'b1;
		end else begin
			col        = pos % COLUMNS;
			may_scroll = 1'b1;
			case (ch)
				CH_BS: begin
					if (col > 0)
						pos--;
					screen[pos] = BLANK_CELL;
				end
				CH_TAB: begin
					// the starting cell is left alone; stop at the screen end
					while ((col % TAB_STOP) != 0 && pos < SCREEN_CELLS) begin
						pos++;
						col++;
						if (pos < SCREEN_CELLS)
							screen[pos] = BLANK_CELL;
					end
				end
				CH_LF: pos += COLUMNS - col;
				CH_CR: pos -= col;
				default: begin
					may_scroll = 1'b0;
					r.status   = STAT_UNKNOWN;
				end
			endcase
		end
		if (may_scroll && pos >= SCREEN_CELLS) begin
			for (int i = 0; i < SCREEN_CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = SCREEN_CELLS - COLUMNS; i < SCREEN_CELLS; i++)
				screen[i] = BLANK_CELL;
			pos = SCREEN_CELLS - COLUMNS;
		end
		cursor_cell  = pos;
		r.cursor_pos = IDX_W'(pos);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (screen[i])
				screen[i] = BLANK_CELL;
			cursor_cell = 0;
			attr_byte   = ATTR_RESET;
			awaited_replies.delete();
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_replies.size() == 0) begin
					$error("result with no item awaiting it: status %0d cell_data %h cursor_pos %0d",
						rsp.status, rsp.cell_data, rsp.cursor_pos);
					mismatches++;
				end else begin
					want = awaited_replies.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.cell_data !== want.cell_data) begin
						$error("cell_data: expected %h, got %h", want.cell_data, rsp.cell_data);
						mismatches++;
					end
					if (rsp.cursor_pos !== want.cursor_pos) begin
						$error("cursor_pos: expected %0d, got %0d", want.cursor_pos,
							rsp.cursor_pos);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				attr_byte = cfg_wdata;
			if (req.valid && req.ready)
				awaited_replies.push_back(emulate_terminal(op_t'(req.op), req.char_code,
					req.cell_index));
			outstanding = awaited_replies.size();
		end
	end

endmodule

// File: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	localparam int SCREEN_CELLS = DEF_COLUMNS * DEF_ROWS;
	localparam int MAX_GAP      = 17;
	localparam int ITEM_TARGET  = 1150;
	localparam int ATTR_PHASE   = 200;   // items between attribute changes
	localparam int LONG_HOLD    = 400;   // cycles the receiver refuses results under pressure
	localparam int STALL_LIMIT  = 20000; // cycles with no handshake before giving up
	localparam int END_PAUSE    = 100;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [ATTR_W-1:0]   cfg_wdata;
	int                  outstanding;
	int                  mismatches;
	int                  sent;
	int                  idle_cycles;
	logic                quiet_source;

	tts_in_if  req ();
	tts_out_if rsp ();

	text_terminal_screen_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	screen_checker watcher (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Watchdog: count cycles in which neither channel moves an item. A scroll walks the
	// whole store and the clearing pass after reset does the same, both well inside the limit.
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [CHAR_W-1:0] any_printable();
		return CHAR_W'($urandom_range(CH_PRINT_MIN, 255));
	endfunction

	// Offer one item after a random gap, hold it until taken, then return on the next
	// falling edge with valid still high so that a back-to-back item needs no re-raise.
	task automatic offer_item(input op_t op, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		int gap;
		// now and then run a stretch of items with no gaps at all
		if (sent % 40 == 0)
			quiet_source = ($urandom_range(0, 2) == 0);
		gap = quiet_source ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.op         <= op;
		req.char_code  <= ch;
		req.cell_index <= idx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Unused fields carry random junk so that every input bit toggles.
	task automatic put_char(input logic [CHAR_W-1:0] ch);
		offer_item(OP_PUT, ch, IDX_W'($urandom_range(0, 2047)));
	endtask

	task automatic read_cell(input int idx);
		offer_item(OP_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
	endtask

	// Drop valid and hold off until every reply has come back.
	task automatic settle();
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	task automatic set_attribute(input logic [ATTR_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One item of a random mix: reads mostly in range, puts mostly printable, plus every
	// control byte the terminal knows and a spread of ones it does not.
	task automatic offer_random();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			if ($urandom_range(0, 9) == 0)
				read_cell($urandom_range(SCREEN_CELLS, 2047));
			else
				read_cell($urandom_range(0, SCREEN_CELLS - 1));
		end else if (pick < 70)
			put_char(any_printable());
		else if (pick < 77)
			put_char(CH_LF);
		else if (pick < 82)
			put_char(CH_CR);
		else if (pick < 88)
			put_char(CH_BS);
		else if (pick < 94)
			put_char(CH_TAB);
		else
			put_char(CHAR_W'($urandom_range(0, CH_PRINT_MIN - 1)));
	endtask

	// Result side: stall each result by a random count, with quiet stretches, and twice
	// refuse results for a long spell so that the block backs up and stalls its input.
	initial begin : result_sink
		int   stall;
		int   taken;
		logic quiet_sink;
		rsp.ready  = 1'b0;
		taken      = 0;
		quiet_sink = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 50 == 0)
				quiet_sink = ($urandom_range(0, 3) == 0);
			stall = quiet_sink ? 0 : $urandom_range(0, MAX_GAP);
			if (taken == 400 || taken == 900)
				stall = LONG_HOLD;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid)
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int kind;
		int next_phase;
		int phase;
		// every input known from the first instant
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		req.valid      = 1'b0;
		req.op         = OP_PUT;
		req.char_code  = '0;
		req.cell_index = '0;
		sent           = 0;
		quiet_source   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The first item waits out the clearing pass after reset.
		read_cell(0);                  // blank cell from the clearing pass
		read_cell(SCREEN_CELLS - 1);   // last cell in range
		read_cell(SCREEN_CELLS);       // first index past the screen
		read_cell(2047);               // all index bits set
		put_char("A");                 // default attribute
		put_char(CH_PRINT_MIN);        // lowest printable byte
		put_char(8'hFF);               // highest printable byte
		put_char(CH_BS);               // step back and blank the cell just written
		read_cell(2);
		put_char(8'd0);                // unrecognised control bytes change nothing
		put_char(CHAR_W'(CH_PRINT_MIN - 1));
		put_char(CH_TAB);              // walk to the next tab stop, blanking as it goes
		put_char(CH_TAB);              // already on a stop: nothing happens
		put_char(CH_CR);
		put_char(CH_BS);               // at column 0 the cursor stays and its cell is blanked
		read_cell(0);
		set_attribute(8'h00);
		put_char(8'd127);
		set_attribute(8'hFF);
		put_char(8'd128);
		put_char(CH_LF);
		read_cell(0);
		read_cell(1);

		// Walk the cursor down to the bottom row. From there it never leaves the last row,
		// so every further line end scrolls the screen.
		repeat (DEF_ROWS - 2) put_char(CH_LF);

		phase      = 0;
		next_phase = sent + ATTR_PHASE;
		while (sent < ITEM_TARGET) begin
			if (sent >= next_phase) begin
				// step through zero, all ones and a random value in turn
				case (phase % 3)
					0:       set_attribute(8'h00);
					1:       set_attribute(8'hFF);
					default: set_attribute(ATTR_W'($urandom_range(1, 254)));
				endcase
				phase++;
				next_phase = sent + ATTR_PHASE;
			end
			kind = $urandom_range(0, 19);
			if (kind < 9)
				repeat ($urandom_range(1, 20)) offer_random();
			else if (kind < 15) begin
				// a line of text, long enough at times to wrap and scroll on its own
				if ($urandom_range(0, 1) == 1)
					put_char(CH_CR);
				repeat ($urandom_range(1, 100)) put_char(any_printable());
				put_char(CH_LF);
			end else if (kind < 18) begin
				// fill the bottom row almost to the end, then tab, which runs off the screen end from column 73 on
				put_char(CH_CR);
				repeat ($urandom_range(70, DEF_COLUMNS - 1)) put_char(any_printable());
				put_char(CH_TAB);
				read_cell($urandom_range(SCREEN_CELLS - 2 * DEF_COLUMNS, SCREEN_CELLS - 1));
			end else if (kind < 19) begin
				// editing near a tab stop: backspaces, tabs and text in a tight mix
				repeat ($urandom_range(4, 12)) begin
					case ($urandom_range(0, 2))
						0:       put_char(CH_BS);
						1:       put_char(CH_TAB);
						default: put_char(any_printable());
					endcase
				end
			end else
				settle();      // pause until every reply is in
		end

		// Hold the input quiet, let the replies drain and give the block a little longer.
		settle();
		repeat (END_PAUSE) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
